[design/edsamp_pkg.sv]
// shared constants, codes and types of the empirical distribution sampler
`timescale 1ns / 1ps

package edsamp_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int CHOSEN_W    = 10;

    localparam int WORD_W      = 31;
    localparam int VALUE_W     = 32;
    localparam int LCG_MUL_W   = 15;
    localparam int PROD_W      = LCG_MUL_W + WORD_W;

    localparam logic [LCG_MUL_W-1:0] LCG_MUL = LCG_MUL_W'(16807);
    localparam logic [WORD_W-1:0]    LCG_MOD = WORD_W'(2147483647);

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_SEED   = 2'd2,
        OP_DRAW   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_MATCH = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_SUM_OVER = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_LCG,
        S_SEARCH,
        S_FINISH
    } fsm_t;

endpackage

[design/empirical_distribution_sampler_core.sv]
// a draw item runs the generator step, then a binary search of the table, then registers its result
// clear, append and seed items pass through the exec and finish states to a valid result
// one item at a time; the next item is taken the cycle after its result is registered
// the search reads one threshold a cycle from the table memory
// reset: generator state one, table empty, running sum zero; no clearing pass
`timescale 1ns / 1ps

module empirical_distribution_sampler_core
    import edsamp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           op,
    input  logic [WORD_W-1:0]    probability,
    input  logic [VALUE_W-1:0]   entry_value,
    input  logic [WORD_W-1:0]    seed_value,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [VALUE_W-1:0]   sample_value,
    output logic [CHOSEN_W-1:0]  chosen_index,
    output logic [WORD_W-1:0]    uniform_draw,
    output logic [1:0]           status
);

    fsm_t                 state_reg, state_next;

    op_t                  op_reg, op_next;
    logic [WORD_W-1:0]    prob_reg, prob_next;
    logic [VALUE_W-1:0]   val_reg, val_next;
    logic [WORD_W-1:0]    seed_reg, seed_next;

    logic [WORD_W-1:0]    gen_reg, gen_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [WORD_W-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]     lo_reg, lo_next;
    logic [CNT_W-1:0]     hi_reg, hi_next;

    logic [VALUE_W-1:0]   res_sample_reg, res_sample_next;
    logic [CHOSEN_W-1:0]  res_index_reg, res_index_next;
    status_t              res_status_reg, res_status_next;

    logic                 out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]   out_sample_reg, out_sample_next;
    logic [CHOSEN_W-1:0]  out_index_reg, out_index_next;
    logic [WORD_W-1:0]    out_draw_reg, out_draw_next;
    status_t              out_status_reg, out_status_next;

    logic [WORD_W-1:0]    thr_mem [TABLE_DEPTH];
    logic [VALUE_W-1:0]   val_mem [TABLE_DEPTH];
    logic [WORD_W-1:0]    thr_rdata_reg;
    logic [VALUE_W-1:0]   val_rdata_reg;
    logic                 mem_we;
    logic [IDX_W-1:0]     wr_addr;
    logic [IDX_W-1:0]     rd_addr;

    logic [CNT_W:0]       span_cur, span_next;
    logic [CNT_W-1:0]     mid_cur;
    logic [WORD_W:0]      add_sum;
    logic                 out_free;
    logic                 lcg_start;
    logic                 lcg_done;
    logic [WORD_W-1:0]    lcg_result;

    edsamp_lcg u_lcg (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (lcg_start),
        .x_in   (gen_reg),
        .done   (lcg_done),
        .result (lcg_result)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign add_sum  = {1'b0, sum_reg} + {1'b0, prob_reg};
    assign wr_addr  = count_reg[IDX_W-1:0];

    // midpoint of the current window, and the read address for the next one
    assign span_cur  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_cur   = span_cur[CNT_W:1];
    assign span_next = {1'b0, lo_next} + {1'b0, hi_next};
    assign rd_addr   = span_next[IDX_W:1];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = (op_reg == OP_DRAW) ? S_LCG : S_FINISH;
            end
            S_LCG:
            begin
                if (lcg_done)
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (lo_reg == hi_reg)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        op_next         = op_reg;
        prob_next       = prob_reg;
        val_next        = val_reg;
        seed_next       = seed_reg;
        gen_next        = gen_reg;
        count_next      = count_reg;
        sum_next        = sum_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        res_sample_next = res_sample_reg;
        res_index_next  = res_index_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_sample_next = out_sample_reg;
        out_index_next  = out_index_reg;
        out_draw_next   = out_draw_reg;
        out_status_next = out_status_reg;
        mem_we          = 1'b0;
        lcg_start       = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next   = op_t'(op);
                    prob_next = probability;
                    val_next  = entry_value;
                    seed_next = seed_value;
                end
            end
            S_EXEC:
            begin
                res_sample_next = '0;
                res_index_next  = '0;
                res_status_next = STAT_OK;
                unique case (op_reg)
                    OP_CLEAR:
                    begin
                        count_next = '0;
                        sum_next   = '0;
                    end
                    OP_APPEND:
                    begin
                        if (count_reg == CNT_W'(TABLE_DEPTH))
                        begin
                            res_status_next = STAT_FULL;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                            if (add_sum[WORD_W])
                            begin
                                sum_next        = LCG_MOD;
                                res_status_next = STAT_SUM_OVER;
                            end
                            else
                            begin
                                sum_next = add_sum[WORD_W-1:0];
                            end
                        end
                    end
                    OP_SEED:
                    begin
                        // seed equal to the modulus reduces to zero and is ignored
                        if (seed_reg != '0 && seed_reg != LCG_MOD)
                        begin
                            gen_next = seed_reg;
                        end
                    end
                    OP_DRAW:
                    begin
                        lcg_start = 1'b1;
                    end
                    default:
                    begin
                        lcg_start = 1'b0;
                    end
                endcase
            end
            S_LCG:
            begin
                if (lcg_done)
                begin
                    gen_next = lcg_result;
                    lo_next  = '0;
                    hi_next  = count_reg;
                end
            end
            S_SEARCH:
            begin
                if (lo_reg != hi_reg)
                begin
                    // thresholds never decrease: keep the first one at or above x
                    if (thr_rdata_reg >= gen_reg)
                    begin
                        hi_next = mid_cur;
                    end
                    else
                    begin
                        lo_next = mid_cur + CNT_W'(1);
                    end
                end
                else if (lo_reg == count_reg)
                begin
                    res_status_next = STAT_NO_MATCH;
                end
                else
                begin
                    res_sample_next = val_rdata_reg;
                    res_index_next  = CHOSEN_W'(lo_reg);
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_sample_next = res_sample_reg;
                    out_index_next  = res_index_reg;
                    out_draw_next   = gen_reg;
                    out_status_next = res_status_reg;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            thr_mem[wr_addr] <= sum_next;
            val_mem[wr_addr] <= val_reg;
        end
        thr_rdata_reg <= thr_mem[rd_addr];
        val_rdata_reg <= val_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_CLEAR;
            prob_reg       <= '0;
            val_reg        <= '0;
            seed_reg       <= '0;
            gen_reg        <= WORD_W'(1);
            count_reg      <= '0;
            sum_reg        <= '0;
            lo_reg         <= '0;
            hi_reg         <= '0;
            res_sample_reg <= '0;
            res_index_reg  <= '0;
            res_status_reg <= STAT_OK;
            out_valid_reg  <= 1'b0;
            out_sample_reg <= '0;
            out_index_reg  <= '0;
            out_draw_reg   <= '0;
            out_status_reg <= STAT_OK;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            prob_reg       <= prob_next;
            val_reg        <= val_next;
            seed_reg       <= seed_next;
            gen_reg        <= gen_next;
            count_reg      <= count_next;
            sum_reg        <= sum_next;
            lo_reg         <= lo_next;
            hi_reg         <= hi_next;
            res_sample_reg <= res_sample_next;
            res_index_reg  <= res_index_next;
            res_status_reg <= res_status_next;
            out_valid_reg  <= out_valid_next;
            out_sample_reg <= out_sample_next;
            out_index_reg  <= out_index_next;
            out_draw_reg   <= out_draw_next;
            out_status_reg <= out_status_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample_value = out_sample_reg;
    assign chosen_index = out_index_reg;
    assign uniform_draw = out_draw_reg;
    assign status       = out_status_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_gen_range: assert property (@(posedge clk) disable iff (!rst_n)
        gen_reg != '0 && gen_reg != LCG_MOD)
        else $error("generator state left its valid range");

    a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SEARCH |-> lo_reg <= hi_reg && hi_reg <= count_reg)
        else $error("search window out of order");

    a_lcg_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        lcg_done |-> state_reg == S_LCG)
        else $error("generator step finished outside a draw");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall && !$stable(state_reg))
        else $error("block took an item without going busy");
`endif

endmodule

[design/edsamp_lcg.sv]
// minimal standard generator step: multiply, then fold modulo 2^31-1
`timescale 1ns / 1ps

module edsamp_lcg
    import edsamp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] x_in,
    output logic              done,
    output logic [WORD_W-1:0] result
);

    logic                busy_reg;
    logic                done_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [WORD_W-1:0]   result_reg;
    logic [WORD_W:0]     fold;
    logic [WORD_W-1:0]   reduced;
    logic [WORD_W-1:0]   result_next;

    // 2^31 = 1 mod (2^31-1): add the high part to the low part
    assign fold = {1'b0, prod_reg[WORD_W-1:0]}
                + (WORD_W+1)'(prod_reg[PROD_W-1:WORD_W]);

    always_comb
    begin
        if (fold >= {1'b0, LCG_MOD})
        begin
            reduced = WORD_W'(fold - {1'b0, LCG_MOD});
        end
        else
        begin
            reduced = fold[WORD_W-1:0];
        end
        // a zero state would stick, restart at one
        result_next = (reduced == '0) ? WORD_W'(1) : reduced;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            prod_reg   <= '0;
            result_reg <= '0;
        end
        else
        begin
            busy_reg <= start;
            done_reg <= busy_reg;
            if (start)
            begin
                prod_reg <= PROD_W'(LCG_MUL) * PROD_W'(x_in);
            end
            if (busy_reg)
            begin
                result_reg <= result_next;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[bench/tb_top.sv]
// testbench for the empirical distribution sampler: directed and random items against a predictor
`timescale 1ns / 1ps

module tb_top
    import edsamp_pkg::*;
();

    typedef struct packed {
        logic [VALUE_W-1:0]  value_word;
        logic [CHOSEN_W-1:0] index;
        logic [WORD_W-1:0]   uniform;
        status_t             stat;
    } draw_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    op_t                 op = OP_CLEAR;
    logic [WORD_W-1:0]   probability = '0;
    logic [VALUE_W-1:0]  entry_value = '0;
    logic [WORD_W-1:0]   seed_value = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [VALUE_W-1:0]  sample_value;
    logic [CHOSEN_W-1:0] chosen_index;
    logic [WORD_W-1:0]   uniform_draw;
    logic [1:0]          status;

    empirical_distribution_sampler_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .probability  (probability),
        .entry_value  (entry_value),
        .seed_value   (seed_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample_value (sample_value),
        .chosen_index (chosen_index),
        .uniform_draw (uniform_draw),
        .status       (status)
    );

    // predictor state
    logic [WORD_W-1:0]  lehmer_state = WORD_W'(1);
    logic [WORD_W-1:0]  thresholds [TABLE_DEPTH];
    logic [VALUE_W-1:0] table_words [TABLE_DEPTH];
    int                 table_count = 0;
    logic [WORD_W-1:0]  threshold_sum = '0;

    draw_result_t pending_draws[$];

    int send_idle_pct = 0;
    int stall_pct = 0;
    int mismatch_count = 0;
    int item_count = 0;
    int draw_count = 0;
    int unmatched_count = 0;
    int full_count = 0;
    int saturated_count = 0;

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("timeout with %0d results outstanding", pending_draws.size());
        $display("empirical_distribution_sampler_core: mismatch");
        $finish;
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    function automatic logic [WORD_W-1:0] lehmer_next(logic [WORD_W-1:0] x);
        longint unsigned prod;
        prod = (64'(x) * 64'(LCG_MUL)) % 64'(LCG_MOD);
        return (prod == 0) ? WORD_W'(1) : WORD_W'(prod);
    endfunction

    function automatic draw_result_t predict_item(op_t o, logic [WORD_W-1:0] p,
                                                  logic [VALUE_W-1:0] v,
                                                  logic [WORD_W-1:0] s);
        draw_result_t r;
        longint unsigned total;
        logic [WORD_W-1:0] reduced;
        r = '0;
        case (o)
            OP_CLEAR:
            begin
                table_count = 0;
                threshold_sum = '0;
            end
            OP_APPEND:
            begin
                if (table_count >= TABLE_DEPTH)
                begin
                    r.stat = STAT_FULL;
                    full_count++;
                end
                else
                begin
                    total = 64'(threshold_sum) + 64'(p);
                    if (total > 64'(LCG_MOD))
                    begin
                        total = 64'(LCG_MOD);
                        r.stat = STAT_SUM_OVER;
                        saturated_count++;
                    end
                    threshold_sum = WORD_W'(total);
                    thresholds[table_count] = threshold_sum;
                    table_words[table_count] = v;
                    table_count++;
                end
            end
            OP_SEED:
            begin
                reduced = WORD_W'(64'(s) % 64'(LCG_MOD));
                if (reduced != 0)
                    lehmer_state = reduced;
            end
            default:
            begin
                lehmer_state = lehmer_next(lehmer_state);
                r.stat = STAT_NO_MATCH;
                draw_count++;
                for (int i = 0; i < table_count; i++)
                begin
                    if (thresholds[i] >= lehmer_state)
                    begin
                        r.value_word = table_words[i];
                        r.index = CHOSEN_W'(i);
                        r.stat = STAT_OK;
                        break;
                    end
                end
                if (r.stat == STAT_NO_MATCH)
                    unmatched_count++;
            end
        endcase
        r.uniform = lehmer_state;
        return r;
    endfunction

    // compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        draw_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_draws.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: value %h index %0d draw %0d status %0d",
                             sample_value, chosen_index, uniform_draw, status);
            end
            else
            begin
                want = pending_draws.pop_front();
                if (sample_value !== want.value_word || chosen_index !== want.index ||
                    uniform_draw !== want.uniform || status !== want.stat)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("result mismatch: expected value %h index %0d draw %0d status %0d",
                                 want.value_word, want.index, want.uniform, want.stat);
                        $display("                 got      value %h index %0d draw %0d status %0d",
                                 sample_value, chosen_index, uniform_draw, status);
                    end
                end
            end
        end
    end

    function automatic logic [WORD_W-1:0] rand_word();
        return WORD_W'($urandom);
    endfunction

    task automatic send_item(op_t o, logic [WORD_W-1:0] p, logic [VALUE_W-1:0] v,
                             logic [WORD_W-1:0] s);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid    <= 1'b1;
        op          <= o;
        probability <= p;
        entry_value <= v;
        seed_value  <= s;
        do @(posedge clk); while (in_stall);
        pending_draws.push_back(predict_item(o, p, v, s));
        item_count++;
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (pending_draws.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_idling(int sender, int receiver);
        send_idle_pct = sender;
        stall_pct = receiver;
    endtask

    task automatic test_empty_table_and_seeds();
        send_item(OP_CLEAR, '0, '0, '0);
        send_item(OP_DRAW, '1, '1, '1);
        // zero and the modulus itself reduce to zero and leave the generator alone
        send_item(OP_SEED, rand_word(), $urandom, '0);
        send_item(OP_SEED, rand_word(), $urandom, LCG_MOD);
        send_item(OP_DRAW, '0, '0, '0);
        send_item(OP_SEED, '0, '0, LCG_MOD - 1);
        send_item(OP_DRAW, rand_word(), $urandom, rand_word());
        send_item(OP_SEED, '1, '1, WORD_W'(1));
        send_item(OP_DRAW, rand_word(), $urandom, rand_word());
    endtask

    task automatic test_append_extremes();
        send_item(OP_CLEAR, '1, '1, '1);
        send_item(OP_APPEND, '0, '0, rand_word());
        send_item(OP_APPEND, LCG_MOD, '1, rand_word());
        send_item(OP_APPEND, WORD_W'(1), 32'hA5A5_5A5A, rand_word());
        send_item(OP_APPEND, '1, 32'h5A5A_A5A5, rand_word());
        repeat (3) send_item(OP_DRAW, rand_word(), $urandom, rand_word());
        // a table whose thresholds mostly sit below the draw
        send_item(OP_CLEAR, rand_word(), $urandom, rand_word());
        send_item(OP_APPEND, WORD_W'(1), $urandom, rand_word());
        send_item(OP_APPEND, WORD_W'(1000), $urandom, rand_word());
        repeat (3) send_item(OP_DRAW, rand_word(), $urandom, rand_word());
    endtask

    task automatic test_full_table();
        send_item(OP_CLEAR, rand_word(), $urandom, rand_word());
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_item(OP_APPEND, WORD_W'(LCG_MOD / TABLE_DEPTH), $urandom, rand_word());
        send_item(OP_APPEND, rand_word(), $urandom, rand_word());
        send_item(OP_APPEND, '1, '1, '1);
        repeat (4) send_item(OP_DRAW, rand_word(), $urandom, rand_word());
        send_item(OP_CLEAR, rand_word(), $urandom, rand_word());
    endtask

    // clear, build a table with a chosen total, maybe reseed, then draw
    task automatic send_table_build();
        int n_entries;
        int shape;
        longint unsigned left;
        longint unsigned p;
        logic [WORD_W-1:0] s;
        n_entries = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 80)
                                                : $urandom_range(1, 16);
        shape = $urandom_range(0, 3);
        if (shape == 2)
            left = 64'($urandom_range(1, LCG_MOD - 1));
        else if (shape == 3)
            left = 64'(LCG_MOD) + 64'($urandom_range(1, LCG_MOD));
        else
            left = 64'(LCG_MOD);
        send_item(OP_CLEAR, rand_word(), $urandom, rand_word());
        for (int i = 0; i < n_entries; i++)
        begin
            if (i == n_entries - 1)
                p = left;
            else
                p = 64'($urandom_range(0, 32'(2 * left / (n_entries - i))));
            if (p > left)
                p = left;
            if (p > 64'(LCG_MOD))
                p = 64'(LCG_MOD);
            left -= p;
            send_item(OP_APPEND, WORD_W'(p), $urandom, rand_word());
        end
        if ($urandom_range(0, 1) == 1)
        begin
            case ($urandom_range(0, 9))
                0: s = '0;
                1: s = LCG_MOD;
                default: s = WORD_W'($urandom_range(1, LCG_MOD - 1));
            endcase
            send_item(OP_SEED, rand_word(), $urandom, s);
        end
        repeat ($urandom_range(1, 12))
            send_item(OP_DRAW, rand_word(), $urandom, rand_word());
    endtask

    task automatic test_random_traffic(int n_items);
        int start;
        start = item_count;
        while (item_count - start < n_items)
        begin
            if ($urandom_range(0, 99) < 85)
                send_table_build();
            else
                send_item(op_t'($urandom_range(0, 3)), rand_word(), $urandom, rand_word());
        end
        wait_drain();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(19, 55);
        test_empty_table_and_seeds();
        test_append_extremes();
        test_full_table();
        test_random_traffic(50);

        set_idling(55, 19);
        test_random_traffic(50);

        set_idling(0, 0);
        test_random_traffic(50);

        repeat (40) @(posedge clk);
        $display("sent %0d items under three idling mixes, %0d of them draws (%0d unmatched)",
                 item_count, draw_count, unmatched_count);
        $display("appends: %0d to a full table, %0d with a saturated sum; %0d mismatches",
                 full_count, saturated_count, mismatch_count);
        if (mismatch_count == 0)
            $display("empirical_distribution_sampler_core: match");
        else
            $display("empirical_distribution_sampler_core: mismatch");
        $finish;
    end

endmodule

[filelist.f]
design/edsamp_pkg.sv
design/edsamp_lcg.sv
design/empirical_distribution_sampler_core.sv
bench/tb_top.sv
